FILE: hdl/hpm_pkg.sv
// ----------------------------------------------------------------------------
// hpm_pkg: shared constants for the homogeneous point map unit
// Default word format and configuration register width.
// ----------------------------------------------------------------------------
package hpm_pkg;

  localparam int unsigned WordBitsDef  = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned LimitBits    = 17;
  localparam int unsigned NumInFields  = 11;

  // field order inside the input tdata word
  localparam int unsigned FldCoefXx = 0;
  localparam int unsigned FldCoefYx = 1;
  localparam int unsigned FldPerspX = 2;
  localparam int unsigned FldCoefXy = 3;
  localparam int unsigned FldCoefYy = 4;
  localparam int unsigned FldPerspY = 5;
  localparam int unsigned FldShiftX = 6;
  localparam int unsigned FldShiftY = 7;
  localparam int unsigned FldWBias  = 8;
  localparam int unsigned FldPointX = 9;
  localparam int unsigned FldPointY = 10;

  localparam logic [LimitBits-1:0] LimitReset = LimitBits'(1);

endpackage

FILE: hdl/hpm_mac.sv
// ----------------------------------------------------------------------------
// hpm_mac: multiply and accumulate stages
// Stage 1 registers the six products, stage 2 sums each row with its
// constant term aligned to the product fraction.
// ----------------------------------------------------------------------------
module hpm_mac #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SUM_BITS  = 66
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [WORD_BITS-1:0] persp_x_i,
  input  logic signed [WORD_BITS-1:0] persp_y_i,
  input  logic signed [WORD_BITS-1:0] w_bias_i,
  input  logic signed [WORD_BITS-1:0] coef_xx_i,
  input  logic signed [WORD_BITS-1:0] coef_xy_i,
  input  logic signed [WORD_BITS-1:0] shift_x_i,
  input  logic signed [WORD_BITS-1:0] coef_yx_i,
  input  logic signed [WORD_BITS-1:0] coef_yy_i,
  input  logic signed [WORD_BITS-1:0] shift_y_i,
  input  logic signed [WORD_BITS-1:0] point_x_i,
  input  logic signed [WORD_BITS-1:0] point_y_i,
  output logic signed [SUM_BITS-1:0]  w_o,
  output logic signed [SUM_BITS-1:0]  nx_o,
  output logic signed [SUM_BITS-1:0]  ny_o
);

  localparam int unsigned PW = 2 * WORD_BITS;

  logic signed [PW-1:0]        pwx_q, pwy_q, pxx_q, pxy_q, pyx_q, pyy_q;
  logic signed [WORD_BITS-1:0] bw_q, bx_q, by_q;
  logic signed [SUM_BITS-1:0]  w_q, nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pwx_q <= persp_x_i * point_x_i;
      pwy_q <= persp_y_i * point_y_i;
      pxx_q <= coef_xx_i * point_x_i;
      pxy_q <= coef_xy_i * point_y_i;
      pyx_q <= coef_yx_i * point_x_i;
      pyy_q <= coef_yy_i * point_y_i;
      bw_q  <= w_bias_i;
      bx_q  <= shift_x_i;
      by_q  <= shift_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q  <= SUM_BITS'(pwx_q) + SUM_BITS'(pwy_q) + (SUM_BITS'(bw_q) <<< FRAC_BITS);
      nx_q <= SUM_BITS'(pxx_q) + SUM_BITS'(pxy_q) + (SUM_BITS'(bx_q) <<< FRAC_BITS);
      ny_q <= SUM_BITS'(pyx_q) + SUM_BITS'(pyy_q) + (SUM_BITS'(by_q) <<< FRAC_BITS);
    end
  end

  assign w_o  = w_q;
  assign nx_o = nx_q;
  assign ny_o = ny_q;

endmodule

FILE: hdl/hpm_div.sv
// ----------------------------------------------------------------------------
// hpm_div: pipelined restoring divider
// One quotient bit per stage. The caller guarantees num < den << QUO_BITS,
// so the top of the numerator seeds the remainder directly.
// ----------------------------------------------------------------------------
module hpm_div #(
  parameter int unsigned NUM_BITS = 99,
  parameter int unsigned DEN_BITS = 66,
  parameter int unsigned QUO_BITS = 33
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  input  logic                neg_i,
  output logic [QUO_BITS-1:0] quo_o,
  output logic                neg_o
);

  logic [DEN_BITS-1:0] rem_q [QUO_BITS];
  logic [DEN_BITS-1:0] den_q [QUO_BITS];
  logic [QUO_BITS-1:0] low_q [QUO_BITS];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS];
  logic                neg_q [QUO_BITS];

  for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
    logic [DEN_BITS-1:0] rem_in, den_in;
    logic [QUO_BITS-1:0] low_in, quo_in;
    logic                neg_in;
    logic [DEN_BITS:0]   trial, diff;

    if (s == 0) begin : g_first
      assign rem_in = num_i[QUO_BITS +: DEN_BITS];
      assign den_in = den_i;
      assign low_in = num_i[QUO_BITS-1:0];
      assign quo_in = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    assign trial = {rem_in, low_in[QUO_BITS-1-s]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        low_q[s] <= low_in;
        neg_q[s] <= neg_in;
        if (!diff[DEN_BITS]) begin
          rem_q[s] <= diff[DEN_BITS-1:0];
          quo_q[s] <= quo_in | (QUO_BITS'(1) << (QUO_BITS-1-s));
        end else begin
          rem_q[s] <= trial[DEN_BITS-1:0];
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_BITS-1];
  assign neg_o = neg_q[QUO_BITS-1];

endmodule

FILE: hdl/homogeneous_point_map_unit.sv
// ----------------------------------------------------------------------------
// homogeneous_point_map_unit: 3x3 projective transform of a 2-D point
// Each input beat carries nine coefficients and a point; each output beat
// carries the mapped point and a success flag.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per point, tdata packs the eleven signed fields.
//   m_axis: one beat per input beat, in order; tdata = mapped_x, mapped_y,
//           tuser = mapped_ok (0 when |w| is zero or under the limit or a quotient
//           leaves the word range; outputs are then zero).
//   cfg: cfg_we_i writes near_zero_limit; write only while the unit is empty.
// Throughput: one beat per cycle while the output is not stalled.
// Pipeline: two multiply/sum stages, one prep stage, WORD_BITS+1 divider
//   stages and one output register; the divider's one-bit-per-stage depth
//   dominates the pipeline length.
// Reset: clears all valid bits and sets near_zero_limit to 1.
// Stall: when m_axis_tready is low with a beat held, the whole pipeline
//   freezes and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module homogeneous_point_map_unit #(
  parameter int unsigned WORD_BITS = hpm_pkg::WordBitsDef,
  parameter int unsigned FRAC_BITS = hpm_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // coef_xx, coef_yx, persp_x, coef_xy, coef_yy, persp_y,
  // shift_x, shift_y, w_bias, point_x, point_y (lowest first), zero padded
  input  logic [((hpm_pkg::NumInFields*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mapped_x, mapped_y (lowest first), zero padded
  output logic [((2*WORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // mapped_ok
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [hpm_pkg::LimitBits-1:0]       cfg_wdata_i
);

  import hpm_pkg::*;

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned SW    = ((2*W > W+F) ? 2*W : W+F) + 2;
  localparam int unsigned QB    = W + 1;
  localparam int unsigned NX    = SW + QB;
  localparam int unsigned DEPTH = 3 + QB;
  localparam int unsigned OBITS = ((2*W+7)/8)*8;

  logic [LimitBits-1:0] limit_q;
  logic                 en;
  logic [DEPTH-1:0]     vld_q;
  logic                 ok_q [DEPTH];

  logic                 out_vld_q;
  logic signed [W-1:0]  out_x_q, out_y_q;
  logic                 out_ok_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // field slices
  logic signed [W-1:0] fld [NumInFields];
  for (genvar i = 0; i < NumInFields; i++) begin : g_fld
    assign fld[i] = s_axis_tdata[i*W +: W];
  end

  logic signed [SW-1:0] w_s, nx_s, ny_s;

  hpm_mac #(
    .WORD_BITS (W),
    .FRAC_BITS (F),
    .SUM_BITS  (SW)
  ) u_mac (
    .clk_i     (clk_i),
    .en_i      (en),
    .persp_x_i (fld[FldPerspX]),
    .persp_y_i (fld[FldPerspY]),
    .w_bias_i  (fld[FldWBias]),
    .coef_xx_i (fld[FldCoefXx]),
    .coef_xy_i (fld[FldCoefXy]),
    .shift_x_i (fld[FldShiftX]),
    .coef_yx_i (fld[FldCoefYx]),
    .coef_yy_i (fld[FldCoefYy]),
    .shift_y_i (fld[FldShiftY]),
    .point_x_i (fld[FldPointX]),
    .point_y_i (fld[FldPointY]),
    .w_o       (w_s),
    .nx_o      (nx_s),
    .ny_o      (ny_s)
  );

  // prep stage: magnitudes, signs, near-zero and quotient range pre-checks
  logic [SW-1:0] w_abs, nx_abs, ny_abs;
  logic [NX-1:0] den_sh, nx_ext, ny_ext, lim_ext, w_ext;
  logic          prep_ok;

  assign w_abs  = w_s[SW-1]  ? SW'(-w_s)  : SW'(w_s);
  assign nx_abs = nx_s[SW-1] ? SW'(-nx_s) : SW'(nx_s);
  assign ny_abs = ny_s[SW-1] ? SW'(-ny_s) : SW'(ny_s);

  assign w_ext   = NX'(w_abs);
  assign den_sh  = NX'(w_abs) << QB;
  assign nx_ext  = NX'(nx_abs) << F;
  assign ny_ext  = NX'(ny_abs) << F;
  assign lim_ext = NX'(limit_q) << F;

  // quotient below 2^QB in both lanes keeps the divider in range
  assign prep_ok = (w_abs != '0) && (w_ext >= lim_ext)
                   && (nx_ext < den_sh) && (ny_ext < den_sh);

  logic [NX-1:0] nx_n_q, ny_n_q;
  logic [SW-1:0] den_q;
  logic          negx_q, negy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_n_q <= prep_ok ? nx_ext : '0;
      ny_n_q <= prep_ok ? ny_ext : '0;
      den_q  <= prep_ok ? w_abs : SW'(1);
      negx_q <= nx_s[SW-1] ^ w_s[SW-1];
      negy_q <= ny_s[SW-1] ^ w_s[SW-1];
    end
  end

  logic [QB-1:0] qx, qy;
  logic          qnx, qny;

  hpm_div #(.NUM_BITS(NX), .DEN_BITS(SW), .QUO_BITS(QB)) u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (nx_n_q), .den_i (den_q),
    .neg_i (negx_q), .quo_o (qx), .neg_o (qnx)
  );

  hpm_div #(.NUM_BITS(NX), .DEN_BITS(SW), .QUO_BITS(QB)) u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i (ny_n_q), .den_i (den_q),
    .neg_i (negy_q), .quo_o (qy), .neg_o (qny)
  );

  // valid bits and success flag ride alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i == 2) begin
          ok_q[i] <= prep_ok;
        end else if (i > 2) begin
          ok_q[i] <= ok_q[i-1];
        end else begin
          ok_q[i] <= 1'b0;
        end
      end
    end
  end

  // final sign and range check
  localparam logic [QB-1:0] Half = QB'(1) << (W - 1);
  logic fit_x, fit_y, fin_ok;

  assign fit_x  = qnx ? (qx <= Half) : (qx < Half);
  assign fit_y  = qny ? (qy <= Half) : (qy < Half);
  assign fin_ok = ok_q[DEPTH-1] && fit_x && fit_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ok_q <= fin_ok;
      out_x_q  <= !fin_ok ? '0 : (qnx ? W'(-qx) : W'(qx));
      out_y_q  <= !fin_ok ? '0 : (qny ? W'(-qy) : W'(qy));
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = OBITS'({out_y_q, out_x_q});

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for homogeneous_point_map_unit
// Streams points with random transforms through the unit under random sender
// gaps and receiver stalls, predicts every output beat with a wide-integer
// model of the projective map and checks beats in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hpm_pkg::*;

  localparam int unsigned WB = WordBitsDef;
  localparam int unsigned FB = FracBitsDef;
  localparam int unsigned IN_W = ((NumInFields*WB+7)/8)*8;
  localparam int unsigned OUT_W = ((2*WB+7)/8)*8;
  localparam int unsigned LATENCY = WB + 5;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef logic signed [WB-1:0] word_t;
  typedef logic signed [127:0] acc_t;
  typedef struct packed {
    word_t x;
    word_t y;
    logic  ok;
  } mapped_t;

  logic clk_i, rst_ni;
  logic [IN_W-1:0] s_tdata;
  logic s_tvalid, s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser, m_tvalid, m_tready;
  logic cfg_we;
  logic [LimitBits-1:0] cfg_wdata;

  homogeneous_point_map_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  logic [IN_W-1:0] point_q[$];
  mapped_t expected_q[$];
  logic [LimitBits-1:0] limit_mdl;
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  int burst_left = 0, gap_left = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic word_t fld(logic [IN_W-1:0] d, int unsigned idx);
    return d[idx*WB +: WB];
  endfunction

  // exact quotient in Q(FB), truncated toward zero; 0 means overflow
  function automatic bit divide_q(acc_t num, acc_t w, output word_t q);
    acc_t n, d, r, half;
    half = acc_t'(1) <<< (WB - 1);
    n = ((num < 0) ? -num : num) <<< FB;
    d = (w < 0) ? -w : w;
    r = n / d;
    if ((num < 0) != (w < 0)) r = -r;
    if (r > half - 1 || r < -half) return 0;
    q = word_t'(r);
    return 1;
  endfunction

  function automatic mapped_t map_point(logic [IN_W-1:0] d);
    acc_t px, py, w, nx, ny, absw;
    mapped_t r;
    px = acc_t'(fld(d, FldPointX));
    py = acc_t'(fld(d, FldPointY));
    w  = acc_t'(fld(d, FldPerspX))*px + acc_t'(fld(d, FldPerspY))*py
         + (acc_t'(fld(d, FldWBias)) <<< FB);
    nx = acc_t'(fld(d, FldCoefXx))*px + acc_t'(fld(d, FldCoefXy))*py
         + (acc_t'(fld(d, FldShiftX)) <<< FB);
    ny = acc_t'(fld(d, FldCoefYx))*px + acc_t'(fld(d, FldCoefYy))*py
         + (acc_t'(fld(d, FldShiftY)) <<< FB);
    absw = (w < 0) ? -w : w;
    r = '0;
    r.ok = (w != 0) && (absw >= (acc_t'(limit_mdl) <<< FB));
    if (r.ok) r.ok = divide_q(nx, w, r.x) && divide_q(ny, w, r.y);
    if (!r.ok) begin
      r.x = '0;
      r.y = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // driver: bursts and gaps; a held beat stays until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(map_point(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 0;
        end else if (point_q.size() > 0) begin
          s_tdata <= point_q.pop_front();
          s_tvalid <= 1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // receiver stall pattern and output check
  always @(posedge clk_i or negedge rst_ni) begin
    mapped_t e;
    if (!rst_ni) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 0);
        end else begin
          e = expected_q.pop_front();
          if (word_t'(m_tdata[WB-1:0]) !== e.x)
            report_mismatch("mapped_x", m_tdata[WB-1:0], e.x);
          if (word_t'(m_tdata[2*WB-1:WB]) !== e.y)
            report_mismatch("mapped_y", m_tdata[2*WB-1:WB], e.y);
          if (m_tuser !== e.ok) report_mismatch("mapped_ok", m_tuser, e.ok);
        end
      end
      if (hold_off) m_tready <= 0;
      else m_tready <= ($urandom_range(7, 0) < 5) || ($urandom_range(63, 0) < 2);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout");
      $display("FAIL homogeneous_point_map_unit");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_item(word_t f[NumInFields]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < NumInFields; i++) d[i*WB +: WB] = f[i];
    return d;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(5, 0))
      0: return word_t'($urandom);
      1: return word_t'(32'sh8000_0000 + $urandom_range(3, 0));
      2: return word_t'(32'sh7fff_ffff - $urandom_range(3, 0));
      3: return word_t'($urandom_range(8, 0)) <<< FB;
      4: return -(word_t'($urandom_range(8, 0)) <<< FB);
      default: return word_t'($signed($urandom_range(1 << 20, 0)) - (1 << 19));
    endcase
  endfunction

  // mostly well-conditioned transforms so that many beats map
  function automatic logic [IN_W-1:0] rand_item();
    word_t f[NumInFields];
    bit tame;
    tame = $urandom_range(3, 0) != 0;
    for (int i = 0; i < NumInFields; i++) begin
      if (tame) f[i] = word_t'($signed($urandom_range(1 << 22, 0)) - (1 << 21));
      else f[i] = rand_word();
    end
    if (tame && $urandom_range(1, 0)) begin
      f[FldPerspX] = $urandom_range(1, 0) ? '0 : word_t'($urandom_range(255, 0)) - 128;
      f[FldPerspY] = $urandom_range(1, 0) ? '0 : word_t'($urandom_range(255, 0)) - 128;
      f[FldWBias] = word_t'($urandom_range(4 << FB, 1 << 10));
    end
    return pack_item(f);
  endfunction

  function automatic logic [IN_W-1:0] affine(word_t sx, word_t sy, word_t px, word_t py,
                                             word_t wb);
    word_t f[NumInFields];
    for (int i = 0; i < NumInFields; i++) f[i] = '0;
    f[FldCoefXx] = sx; f[FldCoefYy] = sy;
    f[FldShiftX] = 32'sh0001_8000; f[FldShiftY] = -32'sh0000_4000;
    f[FldWBias] = wb; f[FldPointX] = px; f[FldPointY] = py;
    return pack_item(f);
  endfunction

  task automatic wait_drained();
    while (point_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitBits-1:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    limit_mdl = v;
    @(posedge clk_i);
    cfg_we <= 0;
    @(posedge clk_i);
  endtask

  task automatic directed_items();
    word_t f[NumInFields];
    point_q.push_back(affine(1 << FB, 1 << FB, 3 << FB, -(5 << FB), 1 << FB));
    point_q.push_back(affine(2 << FB, -(1 << FB), 32'sh7fff_ffff, 32'sh8000_0000,
                             1 << FB));                                  // overflow
    point_q.push_back(affine(1 << FB, 1 << FB, 7 << FB, 7 << FB, '0));  // w zero
    point_q.push_back(affine(1 << FB, 1 << FB, 7 << FB, 7 << FB, 1));   // w tiny
    point_q.push_back(affine(1 << FB, 1 << FB, 7 << FB, 7 << FB, -(3 << FB)));
    point_q.push_back(affine(3 << FB, 1 << FB, -(1 << FB), 1 << FB, 7 << FB)); // rounding
    point_q.push_back(affine(32'sh8000_0000, 32'sh7fff_ffff, 1 << FB, 1 << FB, 1 << FB));
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < NumInFields; i++) f[i] = k ? 32'sh8000_0000 : 32'sh7fff_ffff;
      point_q.push_back(pack_item(f));
    end
    for (int i = 0; i < NumInFields; i++) f[i] = '0;
    point_q.push_back(pack_item(f));
    for (int i = 0; i < NumInFields; i++) f[i] = -1;
    point_q.push_back(pack_item(f));
    // pure perspective: w from persp terms only
    for (int i = 0; i < NumInFields; i++) f[i] = 1 << FB;
    f[FldWBias] = '0; f[FldPerspY] = -(1 << FB);
    f[FldPointX] = 5 << FB; f[FldPointY] = 2 << FB;
    point_q.push_back(pack_item(f));
  endtask

  initial begin
    logic [LimitBits-1:0] limits[5];
    limits = '{17'd0, 17'h1ffff, 17'd65536, 17'd3, 17'd1};
    rst_ni = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    limit_mdl = LimitReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    directed_items();                    // under reset limit
    wait_drained();
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      if (p == 2) directed_items();
      for (int n = 0; n < 200; n++) point_q.push_back(rand_item());
      if (p == 1) begin
        // long receiver hold-off while the sender keeps offering
        repeat (20) @(posedge clk_i);
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      wait_drained();
    end
    if (errors == 0) $display("PASS homogeneous_point_map_unit");
    else $display("FAIL homogeneous_point_map_unit");
    $finish;
  end

endmodule
